// ===== hdl/olm_pkg.sv =====
// Shared constants, codes and command/status types for the ordered list unit.
`default_nettype none

package olm_pkg;

  // Store depth and derived widths.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Field widths of the stream payloads.
  localparam int unsigned ID_W          = 32;
  localparam int unsigned COUNT_FIELD_W = 7;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned IN_TDATA_W    = 32;
  localparam int unsigned OUT_FIELDS_W  = ID_W + 1 + COUNT_FIELD_W + STATUS_W;
  localparam int unsigned OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

  // Operation selector carried in tuser.
  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_DELETE = 1'b1
  } op_cmd_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_FULL     = 2'd2
  } op_status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_SHIFT,
    S_MID,
    S_OUT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;       // capture the accepted transaction, rewind the walk pointer
    logic       app_wr;     // write the id at the tail and bump the count
    logic       step_rd;    // read the entry at the walk pointer and advance it
    logic       hit_take;   // restart the walk just past the matching entry
    logic       shift_wr;   // write the entry read last cycle one slot lower
    logic       cnt_dec;    // drop one entry from the count
    logic       status_wr;  // record the status below
    op_status_e status;
    logic       mid_rd;     // read the middle entry
    logic       out_load;   // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;       // count has reached the capacity
    logic hit;        // the entry read last cycle equals the search id
    logic walk_done;  // pointer is past the last entry and no read is in flight
    logic out_free;   // output register can take a result this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/olm_ctrl.sv =====
// Controller state machine that sequences append, search, shift and middle read.
`default_nettype none

module olm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire olm_pkg::op_cmd_e  in_cmd_i,
  output logic                   in_ready_o,
  input  wire olm_pkg::dp_stat_t stat_i,
  output olm_pkg::dp_cmd_t       cmd_o
);

  olm_pkg::ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      olm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_cmd_i == olm_pkg::CMD_DELETE) ? olm_pkg::S_SCAN : olm_pkg::S_APPEND;
        end
      end
      olm_pkg::S_APPEND: begin
        state_d = olm_pkg::S_MID;
      end
      olm_pkg::S_SCAN: begin
        if (stat_i.hit) begin
          state_d = olm_pkg::S_SHIFT;
        end else if (stat_i.walk_done) begin
          state_d = olm_pkg::S_MID;
        end
      end
      olm_pkg::S_SHIFT: begin
        if (stat_i.walk_done) begin
          state_d = olm_pkg::S_MID;
        end
      end
      olm_pkg::S_MID: begin
        state_d = olm_pkg::S_OUT;
      end
      olm_pkg::S_OUT: begin
        if (stat_i.out_free) begin
          state_d = olm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = olm_pkg::S_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.status = olm_pkg::ST_OK;
    case (state_q)
      olm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      olm_pkg::S_APPEND: begin
        cmd_o.status_wr = 1'b1;
        if (stat_i.full) begin
          cmd_o.status = olm_pkg::ST_FULL;
        end else begin
          cmd_o.app_wr = 1'b1;
        end
      end
      olm_pkg::S_SCAN: begin
        cmd_o.step_rd = 1'b1;
        if (stat_i.hit) begin
          cmd_o.hit_take = 1'b1;
        end else if (stat_i.walk_done) begin
          cmd_o.status_wr = 1'b1;
          cmd_o.status    = olm_pkg::ST_NO_MATCH;
        end
      end
      olm_pkg::S_SHIFT: begin
        cmd_o.step_rd  = 1'b1;
        cmd_o.shift_wr = 1'b1;
        if (stat_i.walk_done) begin
          cmd_o.cnt_dec   = 1'b1;
          cmd_o.status_wr = 1'b1;
        end
      end
      olm_pkg::S_MID: begin
        cmd_o.mid_rd = 1'b1;
      end
      olm_pkg::S_OUT: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/olm_datapath.sv =====
// Datapath: entry memory, count, walk pointer, compare and output register.
`default_nettype none

module olm_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire olm_pkg::dp_cmd_t                   cmd_i,
  output olm_pkg::dp_stat_t                       stat_o,
  input  wire logic [olm_pkg::ID_W-1:0]           in_id_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [olm_pkg::OUT_TDATA_W-1:0]         out_data_o
);

  localparam int unsigned CntW  = olm_pkg::CNT_W;
  localparam int unsigned AddrW = olm_pkg::ADDR_W;
  localparam int unsigned IdW   = olm_pkg::ID_W;

  // Entry memory, one write and one registered read per cycle.
  logic [IdW-1:0] entry_mem [olm_pkg::CAPACITY];

  logic [CntW-1:0]         count_q, count_d;
  logic [CntW-1:0]         ptr_q, ptr_d;
  logic [CntW-1:0]         rd_idx_q, rd_idx_d;
  logic                    rd_vld_q, rd_vld_d;
  logic [IdW-1:0]          id_q;
  logic [IdW-1:0]          rd_data_q;
  olm_pkg::op_status_e     status_q;
  logic                    out_valid_q;
  logic [olm_pkg::OUT_TDATA_W-1:0] out_data_q;

  logic                    ptr_in_range;
  logic                    walk_rd;
  logic                    wr_en;
  logic [AddrW-1:0]        wr_addr;
  logic [IdW-1:0]          wr_data;
  logic                    rd_en;
  logic [AddrW-1:0]        rd_addr;
  logic [CntW-1:0]         idx_below;
  logic [CntW-1:0]         half_count;
  logic                    list_empty;
  logic [IdW-1:0]          middle_id;

  // Walk pointer and memory port selection.
  assign ptr_in_range = (ptr_q < count_q);
  assign walk_rd      = cmd_i.step_rd && ptr_in_range;
  assign idx_below    = rd_idx_q - CntW'(1);
  assign half_count   = count_q >> 1;

  assign wr_en   = cmd_i.app_wr || (cmd_i.shift_wr && rd_vld_q);
  assign wr_addr = cmd_i.app_wr ? count_q[AddrW-1:0] : idx_below[AddrW-1:0];
  assign wr_data = cmd_i.app_wr ? id_q : rd_data_q;
  assign rd_en   = walk_rd || cmd_i.mid_rd;
  assign rd_addr = cmd_i.mid_rd ? half_count[AddrW-1:0] : ptr_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= entry_mem[rd_addr];
    end
  end

  // Next values of the walk and count registers.
  always_comb begin
    ptr_d    = ptr_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = 1'b0;
    count_d  = count_q;
    if (cmd_i.load) begin
      ptr_d = '0;
    end else if (cmd_i.hit_take) begin
      ptr_d = rd_idx_q + CntW'(1);
    end else if (walk_rd) begin
      ptr_d    = ptr_q + CntW'(1);
      rd_idx_d = ptr_q;
      rd_vld_d = 1'b1;
    end
    if (cmd_i.app_wr) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= rd_vld_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result fields.
  assign list_empty = (count_q == '0);
  assign middle_id  = list_empty ? '0 : rd_data_q;

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    if (cmd_i.load) begin
      id_q <= in_id_i;
    end
    if (cmd_i.status_wr) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.out_load) begin
      out_data_q <= {{olm_pkg::OUT_PAD_W{1'b0}}, status_q,
                     olm_pkg::COUNT_FIELD_W'(count_q), list_empty, middle_id};
    end
  end

  // Status back to the controller.
  assign stat_o.full      = (count_q == CntW'(olm_pkg::CAPACITY));
  assign stat_o.hit       = rd_vld_q && (rd_data_q == id_q);
  assign stat_o.walk_done = !ptr_in_range && !rd_vld_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/ordered_list_with_middle_unit.sv =====
// Top level of the ordered list unit with middle-entry report.
//
// The unit keeps up to CAPACITY (64) 32-bit identifiers in arrival order in a
// single-port-write, registered-read memory. Each input transaction carries an
// operation in tuser (0 append, 1 delete) and the identifier in tdata; it gives
// exactly one output transaction with the entry at index floor(count/2), an
// empty flag, the count and a status (0 done, 1 no match, 2 full). One
// transaction is worked at a time. An append writes the identifier at the tail
// (or records the full status), then reads the middle entry and loads the
// output register. A delete walks the memory one entry per cycle to find the
// oldest match at index p, then moves every later entry down one slot, one per
// cycle through the memory's read and write ports, then reads the middle entry.
// A stalled output register holds the unit until the register frees. The input
// is ready again in the cycle after the result is loaded into the output
// register, and a result may wait there while the next transaction is accepted.
// The memory is not cleared at reset.
`default_nettype none

module ordered_list_with_middle_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [olm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [31:0] item_id
  input  wire logic                               s_axis_tuser,   // [0] cmd
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [31:0] middle_id, [32] list_empty, [39:33] entry_count, [41:40] op_status, rest zero
  output logic [olm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

  olm_pkg::dp_cmd_t  dp_cmd;
  olm_pkg::dp_stat_t dp_stat;

  // Sequencing.
  olm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (olm_pkg::op_cmd_e'(s_axis_tuser)),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // Storage and result path.
  olm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .in_id_i     (s_axis_tdata[olm_pkg::ID_W-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== hdl/olm_checker.sv =====
// Port-level checker for the ordered list unit and its bind to the top level.
`default_nettype none

module olm_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [olm_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input wire logic                           s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [olm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  // The empty flag agrees with the count.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[32] == (m_axis_tdata[39:33] == 7'd0)))
    else $error("empty flag disagrees with entry count");

  // An empty list reports a zero middle identifier.
  a_empty_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("empty list with nonzero middle identifier");

  // The status field never carries the unused code.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[41:40] != 2'd3))
    else $error("invalid status code");

  // Only one transaction is worked at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

endmodule

bind ordered_list_with_middle_unit olm_checker u_olm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
